FILE: sv/tslb_pkg.sv
// ----------------------------------------------------------------------------
// tslb_pkg
// Shared widths, constants and register codes of the tick/seconds/LED blinker.
// ----------------------------------------------------------------------------
package tslb_pkg;

    localparam int NUM_LEDS      = 2;
    localparam int LED_SLOTS     = 2;
    localparam int PATTERN_BITS  = 32;

    localparam int RATE_W        = 16;
    localparam int SECONDS_W     = 32;
    localparam int PATTERN_W     = 32;
    localparam int PERIOD_W      = 16;
    localparam int BITS_LEFT_W   = $clog2(PATTERN_BITS + 1);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [RATE_W-1:0]   TICK_RATE_RESET = RATE_W'(100);
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TICK_RATE    = 3'd0,
        REG_LED0_PATTERN = 3'd1,
        REG_LED0_PERIOD  = 3'd2,
        REG_LED1_PATTERN = 3'd3,
        REG_LED1_PERIOD  = 3'd4
    } t_reg_idx;

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_LOAD_SEC = 1'b1
    } t_opcode;

    // Control bundle from the top level to one LED channel
    typedef struct packed {
        logic                  tick;
        logic                  wr_pattern;
        logic                  wr_period;
        logic [CFG_DATA_W-1:0] wdata;
    } t_led_ctl;

endpackage

FILE: sv/tslb_if.sv
// ----------------------------------------------------------------------------
// tslb_if
// Valid/ready channels of the blinker: input items, results, register writes.
// ----------------------------------------------------------------------------
interface tslb_in_if import tslb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [SECONDS_W-1:0] time_value;

    modport source (output valid, opcode, time_value, input ready);
    modport sink   (input valid, opcode, time_value, output ready);
endinterface

interface tslb_out_if import tslb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SECONDS_W-1:0] seconds;
    logic                 second_elapsed;
    logic                 led0_on;
    logic                 led1_on;

    modport source (output valid, seconds, second_elapsed, led0_on, led1_on, input ready);
    modport sink   (input valid, seconds, second_elapsed, led0_on, led1_on, output ready);
endinterface

interface tslb_cfg_if import tslb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/tslb_led.sv
// ----------------------------------------------------------------------------
// tslb_led
// One LED channel: bit countdown, pattern shift register and LED level.
// ----------------------------------------------------------------------------
module tslb_led
    import tslb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_led_ctl i_ctl,
    output logic     o_level_nxt
);

    logic [PATTERN_W-1:0]   r_pattern, n_pattern;
    logic [PERIOD_W-1:0]    r_period, n_period;
    logic [PATTERN_W-1:0]   r_shift, n_shift;
    logic [PERIOD_W-1:0]    r_count, n_count;
    logic [BITS_LEFT_W-1:0] r_bits_left, n_bits_left;
    logic                   r_level, n_level;

    logic [PERIOD_W-1:0]    w_count_dec;
    logic [BITS_LEFT_W-1:0] w_bits_dec;

    assign w_count_dec = r_count - PERIOD_W'(1);
    assign w_bits_dec  = r_bits_left - BITS_LEFT_W'(1);

    always_comb begin
        n_pattern   = r_pattern;
        n_period    = r_period;
        n_shift     = r_shift;
        n_count     = r_count;
        n_bits_left = r_bits_left;
        n_level     = r_level;
        if (i_ctl.wr_pattern || i_ctl.wr_period) begin
            // restart the channel, keep the level
            if (i_ctl.wr_pattern) begin
                n_pattern = i_ctl.wdata[PATTERN_W-1:0];
            end
            if (i_ctl.wr_period) begin
                n_period = i_ctl.wdata[PERIOD_W-1:0];
            end
            n_shift     = i_ctl.wr_pattern ? i_ctl.wdata[PATTERN_W-1:0] : r_pattern;
            n_count     = PERIOD_W'(1);
            n_bits_left = BITS_LEFT_W'(1);
        end else if (i_ctl.tick) begin
            n_count = w_count_dec;
            if (w_count_dec == '0) begin
                n_count     = r_period;
                n_level     = r_shift[0];
                n_shift     = r_shift >> 1;
                n_bits_left = w_bits_dec;
                if (w_bits_dec == '0) begin
                    n_bits_left = BITS_LEFT_W'(PATTERN_BITS);
                    n_shift     = r_pattern;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern   <= '0;
            r_period    <= PERIOD_RESET;
            r_shift     <= '0;
            r_count     <= PERIOD_W'(1);
            r_bits_left <= BITS_LEFT_W'(1);
            r_level     <= 1'b0;
        end else begin
            r_pattern   <= n_pattern;
            r_period    <= n_period;
            r_shift     <= n_shift;
            r_count     <= n_count;
            r_bits_left <= n_bits_left;
            r_level     <= n_level;
        end
    end

    assign o_level_nxt = n_level;

endmodule

FILE: sv/tick_seconds_and_led_pattern_blinker.sv
// ----------------------------------------------------------------------------
// tick_seconds_and_led_pattern_blinker
// Tick prescaler, 32-bit seconds counter and two pattern-driven LED blinkers.
// ----------------------------------------------------------------------------
//   channel   dir  payload                                     transfer when
//   i_in      in   opcode, time_value                          valid & ready
//   o_out     out  seconds, second_elapsed, led0_on, led1_on   valid & ready
//   i_cfg     in   index (3b), data (32b)                      valid & ready
//
// One item per cycle; its result appears in the cycle after its transfer, from
// the result register. All state updates in the cycle of the input transfer.
// Input ready is high while the result register is empty or being drained,
// so a stalled output holds one result and stops further input.
// Reset (synchronous, active low) loads the register reset values; the
// register write port is always ready.
// ----------------------------------------------------------------------------
module tick_seconds_and_led_pattern_blinker
    import tslb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tslb_in_if.sink     i_in,
    tslb_out_if.source  o_out,
    tslb_cfg_if.sink    i_cfg
);

    logic                 w_accept;
    logic                 w_tick;
    logic                 w_cfg_wr;
    logic                 w_sec_done;
    logic [RATE_W-1:0]    w_rate_dec;

    logic [RATE_W-1:0]    r_tick_rate;
    logic [RATE_W-1:0]    r_rate_cnt, n_rate_cnt;
    logic [SECONDS_W-1:0] r_seconds, n_seconds;

    logic                 r_out_valid;
    logic [SECONDS_W-1:0] r_out_seconds;
    logic                 r_out_elapsed;
    logic [LED_SLOTS-1:0] r_out_led;

    t_led_ctl             w_ctl [LED_SLOTS];
    logic [LED_SLOTS-1:0] w_level_nxt;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_tick     = w_accept && (i_in.opcode == OP_TICK);
    assign w_cfg_wr   = i_cfg.valid && i_cfg.ready;

    assign w_rate_dec = r_rate_cnt - RATE_W'(1);
    assign w_sec_done = w_tick && (w_rate_dec == '0);

    always_comb begin
        n_rate_cnt = r_rate_cnt;
        n_seconds  = r_seconds;
        if (w_cfg_wr && i_cfg.index == REG_TICK_RATE) begin
            n_rate_cnt = i_cfg.data[RATE_W-1:0];
        end else if (w_tick) begin
            n_rate_cnt = w_sec_done ? r_tick_rate : w_rate_dec;
        end
        if (w_accept && i_in.opcode == OP_LOAD_SEC) begin
            n_seconds = i_in.time_value;
        end else if (w_sec_done) begin
            n_seconds = r_seconds + SECONDS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_rate <= TICK_RATE_RESET;
            r_rate_cnt  <= TICK_RATE_RESET;
            r_seconds   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr && i_cfg.index == REG_TICK_RATE) begin
                r_tick_rate <= i_cfg.data[RATE_W-1:0];
            end
            r_rate_cnt <= n_rate_cnt;
            r_seconds  <= n_seconds;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload: load on transfer, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_seconds <= n_seconds;
            r_out_elapsed <= w_sec_done;
            r_out_led     <= w_level_nxt;
        end
    end

    always_comb begin
        w_ctl[0].tick       = w_tick && (NUM_LEDS > 0);
        w_ctl[0].wr_pattern = w_cfg_wr && (i_cfg.index == REG_LED0_PATTERN);
        w_ctl[0].wr_period  = w_cfg_wr && (i_cfg.index == REG_LED0_PERIOD);
        w_ctl[0].wdata      = i_cfg.data;
        w_ctl[1].tick       = w_tick && (NUM_LEDS > 1);
        w_ctl[1].wr_pattern = w_cfg_wr && (i_cfg.index == REG_LED1_PATTERN);
        w_ctl[1].wr_period  = w_cfg_wr && (i_cfg.index == REG_LED1_PERIOD);
        w_ctl[1].wdata      = i_cfg.data;
    end

    tslb_led u_led0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl[0]),
        .o_level_nxt (w_level_nxt[0])
    );

    tslb_led u_led1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl[1]),
        .o_level_nxt (w_level_nxt[1])
    );

    assign o_out.valid          = r_out_valid;
    assign o_out.seconds        = r_out_seconds;
    assign o_out.second_elapsed = r_out_elapsed;
    assign o_out.led0_on        = r_out_led[0];
    assign o_out.led1_on        = r_out_led[1];

endmodule

FILE: sv/tslb_chk.sv
// ----------------------------------------------------------------------------
// tslb_chk
// Port-level checks of the blinker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tslb_chk
    import tslb_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_in_opcode,
    input logic [SECONDS_W-1:0] i_in_time_value,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [SECONDS_W-1:0] i_out_seconds,
    input logic                 i_out_elapsed
);

    logic w_in_xfer;
    assign w_in_xfer = i_in_valid && i_in_ready;

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // every input transfer yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> i_out_valid)
        else $error("input transfer without result");

    // a seconds load shows the loaded value and no elapsed second
    a_load_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in_opcode == OP_LOAD_SEC) |=>
            (i_out_seconds == $past(i_in_time_value) && !i_out_elapsed))
        else $error("seconds load not reflected");

    // a stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_seconds)))
        else $error("stalled result changed");

endmodule

bind tick_seconds_and_led_pattern_blinker tslb_chk u_tslb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_opcode     (i_in.opcode),
    .i_in_time_value (i_in.time_value),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_seconds   (o_out.seconds),
    .i_out_elapsed   (o_out.second_elapsed)
);
